### rtl/smeu_pkg.sv
// Package for the stack machine execute unit: opcodes, faults, events, states.
`default_nettype none
package smeu_pkg;

  localparam int unsigned DataWidthDef      = 32;
  localparam int unsigned StackDepthDef     = 64;
  localparam int unsigned OpcodeBytesDef    = 1;
  localparam int unsigned ImmediateBytesDef = 4;

  localparam int unsigned CmdW   = 5;
  localparam int unsigned ImmW   = 32;
  localparam int unsigned PcW    = 16;
  localparam int unsigned FaultW = 3;
  localparam int unsigned EvW    = 2;
  localparam int unsigned CidxW  = 8;

  typedef enum logic [CmdW-1:0] {
    OP_NOP   = 5'd0,  OP_PUSH = 5'd1,  OP_POP  = 5'd2,  OP_LOAD  = 5'd3,
    OP_ADD   = 5'd4,  OP_SUB  = 5'd5,  OP_MUL  = 5'd6,  OP_DIV   = 5'd7,
    OP_MOD   = 5'd8,  OP_XOR  = 5'd9,  OP_AND  = 5'd10, OP_OR    = 5'd11,
    OP_NOT   = 5'd12, OP_EQ   = 5'd13, OP_NE   = 5'd14, OP_GT    = 5'd15,
    OP_LT    = 5'd16, OP_GE   = 5'd17, OP_LE   = 5'd18, OP_JMP   = 5'd19,
    OP_JZ    = 5'd20, OP_JNZ  = 5'd21, OP_PRINT = 5'd22, OP_CALL = 5'd23,
    OP_HALT  = 5'd24
  } opcode_e;

  typedef enum logic [FaultW-1:0] {
    FLT_NONE      = 3'd0,
    FLT_UNDERFLOW = 3'd1,
    FLT_OVERFLOW  = 3'd2,
    FLT_DIVZERO   = 3'd3,
    FLT_INVALID   = 3'd4
  } fault_e;

  typedef enum logic [EvW-1:0] {
    EV_NONE  = 2'd0,
    EV_PRINT = 2'd1,
    EV_CALL  = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_WRITE,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

### rtl/stack_machine_execute_unit.sv
// Stack machine execute unit: operand stack in RAM, read-modify-write per instruction.
//
//  channel | valid/ready        | payload
//  --------+--------------------+-----------------------------------------------
//  request | cmd_valid_i/_ready_o | command_i, immediate_i
//  result  | res_valid_o/_ready_i | top_value_o, next_pc_o, is_halted_o, fault_o,
//          |                    | event_kind_o, event_value_o, call_index_o
//
// One request at a time: accept in idle, three read phases (address top, capture
// top and address second, capture second), execute, write back, then the result.
// A step that writes no stack entry but leaves the stack nonempty re-reads the
// top after write-back, before res_valid_o rises. div/mod pass through the
// shift-subtract divider between execute and write-back.
// Reset clears count, holding register, pc and halted flag; the stack RAM is not
// cleared. A result stalled by res_ready_i holds the unit; the next request is
// taken in the cycle after the result leaves.
`default_nettype none
module stack_machine_execute_unit #(
  parameter int unsigned DATA_WIDTH      = smeu_pkg::DataWidthDef,
  parameter int unsigned STACK_DEPTH     = smeu_pkg::StackDepthDef,
  parameter int unsigned OPCODE_BYTES    = smeu_pkg::OpcodeBytesDef,
  parameter int unsigned IMMEDIATE_BYTES = smeu_pkg::ImmediateBytesDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cmd_valid_i,
  output logic                                     cmd_ready_o,
  input  wire logic [smeu_pkg::CmdW-1:0]           command_i,
  input  wire logic signed [smeu_pkg::ImmW-1:0]    immediate_i,
  output logic                                     res_valid_o,
  input  wire logic                                res_ready_i,
  output logic signed [smeu_pkg::ImmW-1:0]         top_value_o,
  output logic [smeu_pkg::PcW-1:0]                 next_pc_o,
  output logic                                     is_halted_o,
  output logic [smeu_pkg::FaultW-1:0]              fault_o,
  output logic [smeu_pkg::EvW-1:0]                 event_kind_o,
  output logic signed [smeu_pkg::ImmW-1:0]         event_value_o,
  output logic [smeu_pkg::CidxW-1:0]               call_index_o
);

  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DCW  = $clog2(DATA_WIDTH + 1);
  localparam int unsigned OW   = smeu_pkg::ImmW;
  localparam logic [smeu_pkg::PcW-1:0] ShortLen = smeu_pkg::PcW'(OPCODE_BYTES);
  localparam logic [smeu_pkg::PcW-1:0] LongLen  =
    smeu_pkg::PcW'(OPCODE_BYTES + IMMEDIATE_BYTES);
  localparam logic [CW-1:0] Full = CW'(STACK_DEPTH);

  // Stack RAM
  logic [DATA_WIDTH-1:0] mem_q [STACK_DEPTH];
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  smeu_pkg::state_e state_q, state_d;
  logic [1:0]       rph_q, rph_d;   // read phase within ST_READ
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] hold_q, hold_d;
  logic [smeu_pkg::PcW-1:0] pc_q, pc_d;
  logic             halt_q, halt_d;
  smeu_pkg::opcode_e op_q, op_d;
  logic [OW-1:0]    imm_q, imm_d;
  logic [DATA_WIDTH-1:0] a_q, a_d, b_q, b_d, r_q, r_d;
  logic [DATA_WIDTH-1:0] top_q, top_d;
  logic             wr_q, wr_d;
  logic [AW-1:0]    wa_q, wa_d;
  smeu_pkg::fault_e flt_q, flt_d;
  smeu_pkg::event_e ev_q, ev_d;
  logic [OW-1:0]    evv_q, evv_d;
  logic [smeu_pkg::CidxW-1:0] cidx_q, cidx_d;
  // divider
  logic [DATA_WIDTH-1:0] dq_q, dq_d, drem_q, drem_d, dden_q, dden_d;
  logic [DCW-1:0]   dcnt_q, dcnt_d;
  logic             dna_q, dna_d, dnb_q, dnb_d;

  logic [DATA_WIDTH-1:0] ma, mb, prod;
  logic [DATA_WIDTH:0]   dtrial;
  logic [DATA_WIDTH-1:0] dshift;
  logic                  slt_ba, slt_ab;

  assign ma     = a_q[DATA_WIDTH-1] ? (~a_q + 1'b1) : a_q;
  assign mb     = b_q[DATA_WIDTH-1] ? (~b_q + 1'b1) : b_q;
  assign prod   = a_q * b_q;
  assign slt_ba = $signed(b_q) < $signed(a_q);
  assign slt_ab = $signed(a_q) < $signed(b_q);
  assign dshift = {drem_q[DATA_WIDTH-2:0], dq_q[DATA_WIDTH-1]};
  assign dtrial = {1'b0, dshift} - {1'b0, dden_q};

  always_comb begin
    state_d = state_q; rph_d = rph_q; cnt_d = cnt_q; hold_d = hold_q;
    pc_d = pc_q; halt_d = halt_q; op_d = op_q; imm_d = imm_q;
    a_d = a_q; b_d = b_q; r_d = r_q; top_d = top_q; wr_d = wr_q; wa_d = wa_q;
    flt_d = flt_q; ev_d = ev_q; evv_d = evv_q; cidx_d = cidx_q;
    dq_d = dq_q; drem_d = drem_q; dden_d = dden_q; dcnt_d = dcnt_q;
    dna_d = dna_q; dnb_d = dnb_q;
    we = 1'b0; waddr = wa_q; wdata = r_q; raddr = '0;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      smeu_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d  = smeu_pkg::opcode_e'(command_i);
          imm_d = immediate_i;
          rph_d = 2'd0;
          state_d = smeu_pkg::ST_READ;
        end
      end
      smeu_pkg::ST_READ: begin
        // phase 0: address top; 1: capture top, address second; 2: capture second
        raddr = (rph_q == 2'd0) ? AW'(cnt_q - 1'b1) : AW'(cnt_q - 2'd2);
        case (rph_q)
          2'd0: rph_d = 2'd1;
          2'd1: begin
            a_d = (cnt_q != '0) ? rdata_q : '0;
            rph_d = 2'd2;
          end
          default: begin
            b_d = (cnt_q > CW'(1)) ? rdata_q : '0;
            state_d = smeu_pkg::ST_EXEC;
          end
        endcase
      end
      smeu_pkg::ST_EXEC: begin
        flt_d = smeu_pkg::FLT_NONE; ev_d = smeu_pkg::EV_NONE;
        evv_d = '0; cidx_d = '0; wr_d = 1'b0;
        top_d = a_q;
        state_d = smeu_pkg::ST_WRITE;
        if (halt_q) begin
          // ignored
        end else if (op_q > smeu_pkg::OP_HALT) begin
          flt_d = smeu_pkg::FLT_INVALID;
        end else if ((op_q == smeu_pkg::OP_PUSH || op_q == smeu_pkg::OP_LOAD)
                     && cnt_q >= Full) begin
          flt_d = smeu_pkg::FLT_OVERFLOW;
        end else if ((op_q == smeu_pkg::OP_POP || op_q == smeu_pkg::OP_NOT ||
                      (op_q >= smeu_pkg::OP_JZ && op_q <= smeu_pkg::OP_CALL))
                     && cnt_q == '0) begin
          flt_d = smeu_pkg::FLT_UNDERFLOW;
        end else if (op_q >= smeu_pkg::OP_ADD && op_q <= smeu_pkg::OP_LE &&
                     op_q != smeu_pkg::OP_NOT && cnt_q < CW'(2)) begin
          flt_d = smeu_pkg::FLT_UNDERFLOW;
        end else if ((op_q == smeu_pkg::OP_DIV || op_q == smeu_pkg::OP_MOD)
                     && a_q == '0) begin
          flt_d = smeu_pkg::FLT_DIVZERO;
        end else begin
          pc_d = pc_q + ShortLen;
          case (op_q)
            smeu_pkg::OP_PUSH: begin
              r_d = DATA_WIDTH'($signed(imm_q));
              wr_d = 1'b1; wa_d = AW'(cnt_q); cnt_d = cnt_q + 1'b1;
              pc_d = pc_q + LongLen;
            end
            smeu_pkg::OP_POP: begin
              hold_d = a_q; cnt_d = cnt_q - 1'b1;
            end
            smeu_pkg::OP_LOAD: begin
              r_d = hold_q; wr_d = 1'b1; wa_d = AW'(cnt_q); cnt_d = cnt_q + 1'b1;
            end
            smeu_pkg::OP_NOT: begin
              r_d = ~a_q; wr_d = 1'b1; wa_d = AW'(cnt_q - 1'b1);
            end
            smeu_pkg::OP_JMP: pc_d = imm_q[smeu_pkg::PcW-1:0];
            smeu_pkg::OP_JZ, smeu_pkg::OP_JNZ: begin
              if ((op_q == smeu_pkg::OP_JZ) == (a_q == '0)) begin
                cnt_d = cnt_q - 1'b1; pc_d = imm_q[smeu_pkg::PcW-1:0];
              end else begin
                pc_d = pc_q + LongLen;
              end
            end
            smeu_pkg::OP_PRINT: begin
              ev_d = smeu_pkg::EV_PRINT; evv_d = OW'($signed(a_q));
            end
            smeu_pkg::OP_CALL: begin
              ev_d = smeu_pkg::EV_CALL; evv_d = OW'($signed(a_q));
              cidx_d = imm_q[smeu_pkg::CidxW-1:0];
              cnt_d = cnt_q - 1'b1; pc_d = pc_q + LongLen;
            end
            smeu_pkg::OP_HALT: halt_d = 1'b1;
            smeu_pkg::OP_NOP: ;
            default: begin
              wr_d = 1'b1; wa_d = AW'(cnt_q - 2'd2); cnt_d = cnt_q - 1'b1;
              case (op_q)
                smeu_pkg::OP_ADD: r_d = a_q + b_q;
                smeu_pkg::OP_SUB: r_d = b_q - a_q;
                smeu_pkg::OP_MUL: r_d = prod;
                smeu_pkg::OP_XOR: r_d = a_q ^ b_q;
                smeu_pkg::OP_AND: r_d = a_q & b_q;
                smeu_pkg::OP_OR:  r_d = a_q | b_q;
                smeu_pkg::OP_EQ:  r_d = DATA_WIDTH'(a_q == b_q);
                smeu_pkg::OP_NE:  r_d = DATA_WIDTH'(a_q != b_q);
                smeu_pkg::OP_GT:  r_d = DATA_WIDTH'(slt_ba);
                smeu_pkg::OP_LT:  r_d = DATA_WIDTH'(slt_ab);
                smeu_pkg::OP_GE:  r_d = DATA_WIDTH'(!slt_ab);
                smeu_pkg::OP_LE:  r_d = DATA_WIDTH'(!slt_ba);
                default: begin  // div, mod
                  dq_d = mb; drem_d = '0; dden_d = ma;
                  dna_d = a_q[DATA_WIDTH-1]; dnb_d = b_q[DATA_WIDTH-1];
                  dcnt_d = DCW'(DATA_WIDTH);
                  state_d = smeu_pkg::ST_DIV;
                end
              endcase
            end
          endcase
        end
      end
      smeu_pkg::ST_DIV: begin
        // restoring divider, one quotient bit per cycle
        if (dtrial[DATA_WIDTH]) begin
          drem_d = dshift;
          dq_d = {dq_q[DATA_WIDTH-2:0], 1'b0};
        end else begin
          drem_d = dtrial[DATA_WIDTH-1:0];
          dq_d = {dq_q[DATA_WIDTH-2:0], 1'b1};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DCW'(1)) begin
          if (op_q == smeu_pkg::OP_DIV) begin
            r_d = (dna_q != dnb_q) ? (~dq_d + 1'b1) : dq_d;
          end else begin
            r_d = dnb_q ? (~drem_d + 1'b1) : drem_d;
          end
          state_d = smeu_pkg::ST_WRITE;
        end
      end
      smeu_pkg::ST_WRITE: begin
        we = wr_q;
        raddr = AW'(cnt_q - 1'b1);
        state_d = smeu_pkg::ST_OUT;
        // new top forwarded: write lands at cnt-1 when it is the top
        if (wr_q && wa_q == AW'(cnt_q - 1'b1)) begin
          top_d = r_q;
        end else if (cnt_q != '0) begin
          rph_d = 2'd3;  // take the RAM read next cycle
        end
        if (cnt_q == '0) top_d = '0;
        wr_d = 1'b0;
      end
      smeu_pkg::ST_OUT: begin
        if (rph_q == 2'd3) begin
          top_d = rdata_q;
          rph_d = 2'd0;
        end else begin
          res_valid_o = 1'b1;
          if (res_ready_i) state_d = smeu_pkg::ST_IDLE;
        end
      end
      default: state_d = smeu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smeu_pkg::ST_IDLE;
      rph_q   <= 2'd0;
      cnt_q   <= '0;
      hold_q  <= '0;
      pc_q    <= '0;
      halt_q  <= 1'b0;
      wr_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rph_q   <= rph_d;
      cnt_q   <= cnt_d;
      hold_q  <= hold_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      wr_q    <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; imm_q <= imm_d; a_q <= a_d; b_q <= b_d; r_q <= r_d;
    top_q <= top_d; wa_q <= wa_d; flt_q <= flt_d; ev_q <= ev_d;
    evv_q <= evv_d; cidx_q <= cidx_d; dq_q <= dq_d; drem_q <= drem_d;
    dden_q <= dden_d; dcnt_q <= dcnt_d; dna_q <= dna_d; dnb_q <= dnb_d;
  end

  assign top_value_o   = OW'($signed(top_q));
  assign next_pc_o     = pc_q;
  assign is_halted_o   = halt_q;
  assign fault_o       = flt_q;
  assign event_kind_o  = ev_q;
  assign event_value_o = evv_q;
  assign call_index_o  = cidx_q;

  // Stack count never exceeds the depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full) else $error("stack count out of range");
  // A faulting or halted step leaves the count and the pc unchanged.
  a_fault_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smeu_pkg::ST_EXEC && (halt_q || flt_d != smeu_pkg::FLT_NONE))
    |=> $stable(cnt_q) && $stable(pc_q)) else $error("fault changed state");
  // Halt flag never drops.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt flag cleared");
  // Request is taken only when idle and no result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> !res_valid_o) else $error("request taken with result pending");

endmodule
`default_nettype wire
